// ----- design/panel_deploy_supervisor_assert.svh -----
// Assertion macros for the panel deploy supervisor.
// PDS_ASSERT checks a property every cycle outside reset.
// PDS_NEVER checks that a condition never holds outside reset.
`ifndef PANEL_DEPLOY_SUPERVISOR_ASSERT_SVH
`define PANEL_DEPLOY_SUPERVISOR_ASSERT_SVH
`ifndef SYNTH
`define PDS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pds assertion failed");
`define PDS_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("pds forbidden condition seen");
`else
`define PDS_ASSERT(lbl, prop)
`define PDS_NEVER(lbl, cond)
`endif
`endif

// ----- design/pds_pkg.sv -----
package pds_pkg;

	typedef logic [2:0] status_t;
	typedef logic [1:0] op_t;
	typedef logic [1:0] kind_t;

	localparam status_t ST_IDLE     = 3'd0;
	localparam status_t ST_CMD      = 3'd1;
	localparam status_t ST_DEPLOYED = 3'd2;
	localparam status_t ST_TIMEOUT  = 3'd3;
	localparam status_t ST_HOT      = 3'd4;

	localparam op_t OP_MAIN  = 2'd0;
	localparam op_t OP_RED   = 2'd1;
	localparam op_t OP_CHECK = 2'd2;

	localparam kind_t KIND_NONE = 2'd0;
	localparam kind_t KIND_MAIN = 2'd1;
	localparam kind_t KIND_RED  = 2'd2;

	localparam logic CFG_HEATER_TIMEOUT = 1'b0;
	localparam logic CFG_OVERHEAT_LIMIT = 1'b1;

	localparam logic [31:0] HEATER_TIMEOUT_RST = 32'd10;
	localparam logic [11:0] OVERHEAT_LIMIT_RST = 12'd4095;

	// one request as held in the input register
	typedef struct packed {
		op_t         op;
		logic [31:0] cycle_count;
		logic        sensed1;
		logic        sensed2;
		logic [11:0] temp1;
		logic [11:0] temp2;
	} item_t;

endpackage

// ----- design/pds_in_reg.sv -----
module pds_in_reg
	import pds_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t item_in,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic take;

	// full and not draining this cycle
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ----- design/pds_advance.sv -----
module pds_advance
	import pds_pkg::*;
(
	input  status_t     status,
	input  logic [31:0] start,
	input  logic [31:0] now,
	input  logic        sensed,
	input  logic [11:0] temp,
	input  logic [31:0] heater_timeout,
	input  logic [11:0] overheat_limit,
	output status_t     status_next
);

	logic [31:0] elapsed;

	// wraps modulo 2^32 like the cycle counter
	assign elapsed = now - start;

	always_comb begin
		status_next = status;
		if (status == ST_CMD) begin
			if (sensed) begin
				status_next = ST_DEPLOYED;
			end else if (heater_timeout <= elapsed) begin
				status_next = ST_TIMEOUT;
			end else if (temp >= overheat_limit) begin
				status_next = ST_HOT;
			end
		end
	end

endmodule

// ----- design/panel_deploy_supervisor.sv -----
// Panel deploy supervisor: tracks a two-panel deployment driven by a main
// and a redundant heater.
// Input channel (in_valid / in_stall): one request per accepted cycle.
//   op 0 = main deploy, 1 = redundant deploy, 2 = status check, 3 = no-op.
// Output channel (out_valid / out_stall): exactly one result per request,
//   in order: both panel statuses after the request, the statuses reported
//   before a check's update (zero otherwise), and both heater drive bits.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 writes
//   heater_timeout, index 1 writes overheat_limit (low 12 bits of data).
//   Write only while no request is in flight.
// Order: input register, then the result register when it has room.
// Throughput: one request per cycle unless stalled; the input register and
//   the result register form a two-stage pipe, so a request is taken while
//   a result waits. The state update is one pass of compare/subtract logic.
// Stall: when the result is stalled the held request stays in the input
//   register and in_stall rises only once that register is full too.
// Reset: all panels not deployed, drives off, no command active,
//   heater_timeout = 10, overheat_limit = 4095, both channels empty.
module panel_deploy_supervisor
	import pds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] cycle_count,
	input  logic        panel1_sensed,
	input  logic        panel2_sensed,
	input  logic [11:0] panel1_temp,
	input  logic [11:0] panel2_temp,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  panel1_state,
	output logic [2:0]  panel2_state,
	output logic [2:0]  panel1_reported,
	output logic [2:0]  panel2_reported,
	output logic        main_drive,
	output logic        red_drive,
	// config channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	// config registers
	logic [31:0] heater_timeout_q;
	logic [11:0] overheat_limit_q;

	// deployment state; both panels always share one start time
	status_t     p1_status_q, p2_status_q;
	logic [31:0] start_q;
	kind_t       kind_q;
	logic        main_q, red_q;

	// pipe control
	item_t item_in, item_s1;
	logic  valid_s1;
	logic  advance;

	// next state
	status_t     p1_adv, p2_adv;
	status_t     p1_d, p2_d, rep1_d, rep2_d;
	logic [31:0] start_d;
	kind_t       kind_d;
	logic        main_d, red_d;
	logic        finish;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_timeout_q <= HEATER_TIMEOUT_RST;
			overheat_limit_q <= OVERHEAT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HEATER_TIMEOUT: heater_timeout_q <= cfg_data;
				CFG_OVERHEAT_LIMIT: overheat_limit_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign item_in = '{
		op:          op,
		cycle_count: cycle_count,
		sensed1:     panel1_sensed,
		sensed2:     panel2_sensed,
		temp1:       panel1_temp,
		temp2:       panel2_temp
	};

	// move the held request into the result register when it has room
	assign advance = valid_s1 && (!out_valid || !out_stall);

	pds_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pds_advance u_adv1 (
		.status         (p1_status_q),
		.start          (start_q),
		.now            (item_s1.cycle_count),
		.sensed         (item_s1.sensed1),
		.temp           (item_s1.temp1),
		.heater_timeout (heater_timeout_q),
		.overheat_limit (overheat_limit_q),
		.status_next    (p1_adv)
	);

	pds_advance u_adv2 (
		.status         (p2_status_q),
		.start          (start_q),
		.now            (item_s1.cycle_count),
		.sensed         (item_s1.sensed2),
		.temp           (item_s1.temp2),
		.heater_timeout (heater_timeout_q),
		.overheat_limit (overheat_limit_q),
		.status_next    (p2_adv)
	);

	// deployment done or failed after a check's update
	assign finish = (p1_adv == ST_DEPLOYED && p2_adv == ST_DEPLOYED) ||
		p1_adv == ST_TIMEOUT || p2_adv == ST_TIMEOUT ||
		p1_adv == ST_HOT || p2_adv == ST_HOT;

	always_comb begin
		p1_d    = p1_status_q;
		p2_d    = p2_status_q;
		rep1_d  = ST_IDLE;
		rep2_d  = ST_IDLE;
		start_d = start_q;
		kind_d  = kind_q;
		main_d  = main_q;
		red_d   = red_q;
		unique case (item_s1.op)
			OP_MAIN: begin
				main_d  = 1'b1;
				p1_d    = ST_CMD;
				p2_d    = ST_CMD;
				start_d = item_s1.cycle_count;
				kind_d  = KIND_MAIN;
			end
			OP_RED: begin
				// a newer command takes over; the older drive stays on
				red_d   = 1'b1;
				p1_d    = ST_CMD;
				p2_d    = ST_CMD;
				start_d = item_s1.cycle_count;
				kind_d  = KIND_RED;
			end
			OP_CHECK: begin
				rep1_d = p1_status_q;
				rep2_d = p2_status_q;
				p1_d   = p1_adv;
				p2_d   = p2_adv;
				if (finish && kind_q == KIND_MAIN) begin
					main_d = 1'b0;
					kind_d = KIND_NONE;
				end else if (finish && kind_q == KIND_RED) begin
					red_d  = 1'b0;
					kind_d = KIND_NONE;
				end
			end
			default: ; // op 3 leaves everything as is
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_status_q <= ST_IDLE;
			p2_status_q <= ST_IDLE;
			start_q     <= '0;
			kind_q      <= KIND_NONE;
			main_q      <= 1'b0;
			red_q       <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (advance) begin
				p1_status_q <= p1_d;
				p2_status_q <= p2_d;
				start_q     <= start_d;
				kind_q      <= kind_d;
				main_q      <= main_d;
				red_q       <= red_d;
				out_valid   <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			panel1_state    <= p1_d;
			panel2_state    <= p2_d;
			panel1_reported <= rep1_d;
			panel2_reported <= rep2_d;
			main_drive      <= main_d;
			red_drive       <= red_d;
		end
	end

`include "panel_deploy_supervisor_assert.svh"

	// an active command always has its drive on
	`PDS_ASSERT(a_main_kind_drive, (kind_q == KIND_MAIN) |-> main_q)
	`PDS_ASSERT(a_red_kind_drive, (kind_q == KIND_RED) |-> red_q)
	// a stalled result freezes the deployment state
	`PDS_ASSERT(a_stall_holds_state,
		(out_valid && out_stall) |=> ($stable(p1_status_q) && $stable(kind_q)))
	`PDS_NEVER(a_status_range, p1_status_q > ST_HOT || p2_status_q > ST_HOT)

endmodule
